FILE: src/sal_pkg.sv
// ----------------------------------------------------------------------------
// sal_pkg
// Shared sizes, operation and status codes and the per-cell command type
// for the shifting array list.
// ----------------------------------------------------------------------------
package sal_pkg;

  // list size; entry index and fill count widths follow from it
  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // fixed beat field widths
  localparam int DATA_W   = 32;
  localparam int KIND_W   = 3;
  localparam int INDEX_W  = 4;
  localparam int STATUS_W = 2;
  localparam int FILL_W   = 5;

  // width used to compare the request index with the fill count
  localparam int CMP_W    = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

  typedef enum logic [KIND_W-1:0] {
    KIND_READ       = 3'd0,
    KIND_WRITE      = 3'd1,
    KIND_INSERT_AT  = 3'd2,
    KIND_REMOVE_AT  = 3'd3,
    KIND_PUSH_END   = 3'd4,
    KIND_POP_END    = 3'd5,
    KIND_PUSH_FRONT = 3'd6,
    KIND_POP_FRONT  = 3'd7
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_INDEX = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_e;

  // what every cell does in this cycle
  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_WRITE,   // load value at pos
    ACT_INSERT,  // load value at pos, cells above take their lower neighbor
    ACT_REMOVE   // cells at and above pos take their upper neighbor
  } cell_act_e;

  typedef struct packed {
    cell_act_e          act;
    logic [IDX_W-1:0]   pos;
    logic [DATA_W-1:0]  value;
  } cell_cmd_t;

endpackage

FILE: src/sal_cell.sv
// ----------------------------------------------------------------------------
// sal_cell
// One list entry. Holds, loads the broadcast value, or takes the entry of
// its lower or upper neighbor depending on the broadcast command.
// ----------------------------------------------------------------------------
module sal_cell
  import sal_pkg::*;
(
  input  logic              clk_i,
  input  logic [IDX_W-1:0]  cell_idx_i,
  input  cell_cmd_t         cmd_i,
  input  logic [DATA_W-1:0] lower_i,
  input  logic [DATA_W-1:0] upper_i,
  output logic [DATA_W-1:0] entry_o
);

  logic [DATA_W-1:0] entry_q, entry_d;
  logic              hit, above;

  assign hit   = (cell_idx_i == cmd_i.pos);
  assign above = (cell_idx_i > cmd_i.pos);

  // next entry
  always_comb begin
    entry_d = entry_q;
    case (cmd_i.act)
      ACT_WRITE: begin
        if (hit) entry_d = cmd_i.value;
      end
      ACT_INSERT: begin
        if (hit)        entry_d = cmd_i.value;
        else if (above) entry_d = lower_i;
      end
      ACT_REMOVE: begin
        if (hit || above) entry_d = upper_i;
      end
      default: entry_d = entry_q;
    endcase
  end

  // payload storage, undefined until written
  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

FILE: src/sal_ctrl.sv
// ----------------------------------------------------------------------------
// sal_ctrl
// Operation decoder: checks the request against the fill count, picks the
// status and the next count, and builds the command broadcast to the cells.
// ----------------------------------------------------------------------------
module sal_ctrl
  import sal_pkg::*;
(
  input  logic [KIND_W-1:0]  kind_i,
  input  logic [INDEX_W-1:0] index_i,
  input  logic [DATA_W-1:0]  value_i,
  input  logic [CNT_W-1:0]   count_i,
  output cell_cmd_t          cmd_o,
  output status_e            status_o,
  output logic [CNT_W-1:0]   count_o,
  output logic               read_ok_o
);

  logic in_range, full, empty;

  assign in_range = (CMP_W'(index_i) < CMP_W'(count_i));
  assign full     = (count_i == CNT_W'(CAPACITY));
  assign empty    = (count_i == '0);

  always_comb begin
    cmd_o.act   = ACT_NONE;
    cmd_o.pos   = IDX_W'(index_i);
    cmd_o.value = value_i;
    status_o    = ST_OK;
    count_o     = count_i;
    read_ok_o   = 1'b0;
    case (kind_e'(kind_i))
      KIND_READ: begin
        if (in_range) read_ok_o = 1'b1;
        else          status_o  = ST_BAD_INDEX;
      end
      KIND_WRITE: begin
        if (in_range) cmd_o.act = ACT_WRITE;
        else          status_o  = ST_BAD_INDEX;
      end
      KIND_INSERT_AT: begin
        // full list is reported before the index check
        if (full) begin
          status_o = ST_FULL;
        end else if (!in_range) begin
          status_o = ST_BAD_INDEX;
        end else begin
          cmd_o.act = ACT_INSERT;
          count_o   = count_i + CNT_W'(1);
        end
      end
      KIND_REMOVE_AT: begin
        if (!in_range) begin
          status_o = ST_BAD_INDEX;
        end else begin
          cmd_o.act = ACT_REMOVE;
          count_o   = count_i - CNT_W'(1);
        end
      end
      KIND_PUSH_END: begin
        if (full) begin
          status_o = ST_FULL;
        end else begin
          cmd_o.act = ACT_WRITE;
          cmd_o.pos = IDX_W'(count_i);
          count_o   = count_i + CNT_W'(1);
        end
      end
      KIND_POP_END: begin
        if (empty) status_o = ST_EMPTY;
        else       count_o  = count_i - CNT_W'(1);
      end
      KIND_PUSH_FRONT: begin
        // on an empty list an insert at the front places the sole entry
        if (full) begin
          status_o = ST_FULL;
        end else begin
          cmd_o.act = ACT_INSERT;
          cmd_o.pos = '0;
          count_o   = count_i + CNT_W'(1);
        end
      end
      KIND_POP_FRONT: begin
        // empty list fails like a remove at index zero
        if (empty) begin
          status_o = ST_BAD_INDEX;
        end else begin
          cmd_o.act = ACT_REMOVE;
          cmd_o.pos = '0;
          count_o   = count_i - CNT_W'(1);
        end
      end
      default: status_o = ST_OK;
    endcase
  end

endmodule

FILE: src/shifting_array_list_core.sv
// ----------------------------------------------------------------------------
// shifting_array_list_core
// Bounded contiguous list built as a row of entry cells. Insert and remove
// shift the cells above the position (remove: also the cell at it) at once.
// ----------------------------------------------------------------------------
// The result is registered in the cycle after the input beat is accepted.
// Throughput: one operation per cycle while not stalled; every cell updates in the same cycle.
// Input stalls only while a result is held and the output side is stalled.
// Reset clears the fill count and the output valid; entry storage is not
// reset and is only read at positions below the fill count.
module shifting_array_list_core
  import sal_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [KIND_W-1:0]         kind_i,
  input  logic [INDEX_W-1:0]        index_i,
  input  logic signed [DATA_W-1:0]  value_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [DATA_W-1:0]  read_value_o,
  output logic [STATUS_W-1:0]       status_o,
  output logic [FILL_W-1:0]         fill_count_o
);

  logic              accept;
  logic [CNT_W-1:0]  count_q, count_d;
  cell_cmd_t         dec_cmd, cell_cmd;
  status_e           dec_status;
  logic              read_ok;
  logic [DATA_W-1:0] cell_data [CAPACITY];
  logic [DATA_W-1:0] rd_data;

  logic                     out_valid_q;
  logic [DATA_W-1:0]        read_value_q;
  status_e                  status_q;
  logic [FILL_W-1:0]        fill_q;

  // handshake
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  // operation decode
  sal_ctrl u_ctrl (
    .kind_i    (kind_i),
    .index_i   (index_i),
    .value_i   (value_i),
    .count_i   (count_q),
    .cmd_o     (dec_cmd),
    .status_o  (dec_status),
    .count_o   (count_d),
    .read_ok_o (read_ok)
  );

  // cells only act on an accepted beat
  always_comb begin
    cell_cmd = dec_cmd;
    if (!accept) cell_cmd.act = ACT_NONE;
  end

  // row of entry cells
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [DATA_W-1:0] lower, upper;
    if (g == 0) begin : g_first
      assign lower = '0;
    end else begin : g_mid_lo
      assign lower = cell_data[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign upper = '0;
    end else begin : g_mid_hi
      assign upper = cell_data[g+1];
    end
    sal_cell u_cell (
      .clk_i      (clk_i),
      .cell_idx_i (IDX_W'(g)),
      .cmd_i      (cell_cmd),
      .lower_i    (lower),
      .upper_i    (upper),
      .entry_o    (cell_data[g])
    );
  end

  // read port
  assign rd_data = read_ok ? cell_data[IDX_W'(index_i)] : '0;

  // fill count and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) count_q <= count_d;
      if (accept)           out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      read_value_q <= rd_data;
      status_q     <= dec_status;
      fill_q       <= FILL_W'(count_d);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign read_value_o = read_value_q;
  assign status_o     = status_q;
  assign fill_count_o = fill_q;

  // checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("fill count above capacity");

  a_fail_keeps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && dec_status != ST_OK |=> $stable(count_q))
    else $error("failed operation changed the fill count");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_q && fill_q == FILL_W'(count_q))
    else $error("result beat missing or fill count mismatch");

  a_read_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && read_value_q != '0 |-> status_q == ST_OK)
    else $error("nonzero read value on a failed operation");

endmodule
